[rtl/core/fhfbe_pkg.sv]
// ----------------------------------------------------------------------------
// fhfbe_pkg: shared definitions for the fade/hold/fade/blink envelope
// operation codes, mode codes, register indexes and divider control types
// ----------------------------------------------------------------------------
`default_nettype none

package fhfbe_pkg;

    localparam int REG_W     = 24;
    localparam int NOW_W     = 32;
    localparam int CFG_IDX_W = 3;

    // request operation codes
    localparam logic [1:0] OP_TICK       = 2'd0;
    localparam logic [1:0] OP_FADE_OUT   = 2'd1;
    localparam logic [1:0] OP_FADE_IN    = 2'd2;
    localparam logic [1:0] OP_BLINK      = 2'd3;

    // envelope modes share the start code values
    localparam logic [1:0] MODE_NONE     = 2'd0;
    localparam logic [1:0] MODE_FADE_OUT = 2'd1;
    localparam logic [1:0] MODE_FADE_IN  = 2'd2;
    localparam logic [1:0] MODE_BLINK    = 2'd3;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_FIRST_RAMP   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_HOLD         = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_SECOND_RAMP  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_BLINK_TOTAL  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_BLINK_PERIOD = 3'd4;

    typedef struct packed {
        logic start;
        logic blink;
    } t_div_ctl;

endpackage

`default_nettype wire

[rtl/core/fhfbe_div.sv]
// ----------------------------------------------------------------------------
// fhfbe_div: iterative restoring divider
// one shared compare-subtract step per cycle while busy, one quotient bit per step
// ----------------------------------------------------------------------------
`default_nettype none

module fhfbe_div #(
    parameter int DVD_BITS = 32,
    parameter int QUO_BITS = 17,
    parameter int CNT_W    = $clog2(DVD_BITS + 1)
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  fhfbe_pkg::t_div_ctl            i_ctl,
    input  logic [DVD_BITS-1:0]            i_dvd,
    input  logic [fhfbe_pkg::REG_W-1:0]    i_rem,
    input  logic [fhfbe_pkg::REG_W-1:0]    i_dsr,
    output logic [QUO_BITS-1:0]            o_quo,
    output logic                           o_done
);
    import fhfbe_pkg::*;

    localparam logic [CNT_W-1:0] BLINK_STEPS = CNT_W'(DVD_BITS);
    localparam logic [CNT_W-1:0] RAMP_STEPS  = CNT_W'(QUO_BITS);

    logic [REG_W-1:0]    r_rem, n_rem;
    logic [REG_W-1:0]    r_dsr;
    logic [DVD_BITS-1:0] r_dvd;
    logic [QUO_BITS-1:0] r_quo;
    logic [CNT_W-1:0]    r_cnt, n_cnt;
    logic                r_busy, n_busy;
    logic                r_done, n_done;

    logic [REG_W:0]      w_trial;
    logic [REG_W:0]      w_diff;
    logic                w_ge;

    // shared compare-subtract step
    assign w_trial = {r_rem, r_dvd[DVD_BITS-1]};
    assign w_ge    = (w_trial >= {1'b0, r_dsr});
    assign w_diff  = w_trial - {1'b0, r_dsr};

    always_comb begin
        n_rem  = w_ge ? w_diff[REG_W-1:0] : w_trial[REG_W-1:0];
        n_cnt  = r_cnt;
        n_busy = r_busy;
        n_done = 1'b0;
        if (i_ctl.start) begin
            n_cnt  = i_ctl.blink ? BLINK_STEPS : RAMP_STEPS;
            n_busy = 1'b1;
        end else if (r_busy) begin
            n_cnt = r_cnt - CNT_W'(1);
            if (r_cnt == CNT_W'(1)) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
            r_cnt  <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.start) begin
            r_rem <= i_rem;
            r_dsr <= i_dsr;
            r_dvd <= i_dvd;
            r_quo <= '0;
        end else if (r_busy) begin
            r_rem <= n_rem;
            r_dvd <= {r_dvd[DVD_BITS-2:0], 1'b0};
            r_quo <= {r_quo[QUO_BITS-2:0], w_ge};
        end
    end

    assign o_quo  = r_quo;
    assign o_done = r_done;

endmodule

`default_nettype wire

[rtl/core/fade_hold_fade_blink_envelope.sv]
// ----------------------------------------------------------------------------
// fade_hold_fade_blink_envelope: visibility envelope generator
// Each request carries an opcode and the current time in ms. Start requests
// (fade-out combo, fade-in combo, blink) stamp the time and report full
// visibility. Tick requests work out the elapsed time and report the level:
// linear ramp / hold / linear ramp for the combos, on/off for blink.
// Channels: request (i_in_valid/o_in_ready), result (o_out_valid/
// i_out_ready), configuration write (i_cfg_valid/o_cfg_ready, always ready).
// A start or an idle tick goes from S_IDLE through S_DONE to the result
// register; a tick that settles without a divide also passes S_DECIDE, and
// ramp and blink ticks wait in S_DIV for the radix-2 divider, which forms
// one quotient bit per cycle.
// One request is in flight at a time: o_in_ready is high only when idle.
// The result sits in an output register; a stalled receiver holds the
// block in its final state until the result register frees up.
// Reset clears the configuration registers and the start stamp to zero,
// the level to full visibility and the envelope to inactive.
// ----------------------------------------------------------------------------
`default_nettype none

module fade_hold_fade_blink_envelope #(
    parameter int TIME_BITS     = 32,
    parameter int FRACTION_BITS = 16
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_in_valid,
    output logic                              o_in_ready,
    input  logic [1:0]                        i_opcode,
    input  logic [fhfbe_pkg::NOW_W-1:0]       i_now_ms,
    output logic                              o_out_valid,
    input  logic                              i_out_ready,
    output logic [FRACTION_BITS:0]            o_visibility,
    output logic                              o_running,
    input  logic                              i_cfg_valid,
    output logic                              o_cfg_ready,
    input  logic [fhfbe_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  logic [fhfbe_pkg::REG_W-1:0]       i_cfg_data
);
    import fhfbe_pkg::*;

    localparam int LVL_W    = FRACTION_BITS + 1;
    localparam int SUM_W    = REG_W + 2;
    localparam int CW       = (TIME_BITS > SUM_W) ? TIME_BITS : SUM_W;
    localparam int DVD_BITS = (TIME_BITS > LVL_W) ? TIME_BITS : LVL_W;
    localparam int CNT_W    = $clog2(DVD_BITS + 1);
    localparam logic [LVL_W-1:0] ONE = {1'b1, {FRACTION_BITS{1'b0}}};

    localparam logic [1:0] S_IDLE   = 2'd0;
    localparam logic [1:0] S_DECIDE = 2'd1;
    localparam logic [1:0] S_DIV    = 2'd2;
    localparam logic [1:0] S_DONE   = 2'd3;

    logic [1:0]           r_state, n_state;
    logic [1:0]           r_mode, n_mode;
    logic                 r_active, n_active;
    logic [TIME_BITS-1:0] r_start, n_start;
    logic [TIME_BITS-1:0] r_e, n_e;
    logic [LVL_W-1:0]     r_level, n_level;
    logic                 r_out_valid, n_out_valid;
    logic [LVL_W-1:0]     r_vis, n_vis;
    logic                 r_run, n_run;

    logic [REG_W-1:0]     r_first, r_hold, r_second, r_total, r_period;

    logic [TIME_BITS-1:0] w_now;
    logic [CW-1:0]        w_e_c;
    logic [SUM_W-1:0]     w_ah, w_ahb;
    logic [REG_W-1:0]     w_e24, w_x24;
    logic                 w_fo;

    t_div_ctl             w_div_ctl;
    logic [REG_W-1:0]     w_num, w_dsr, w_rem;
    logic [DVD_BITS-1:0]  w_dvd;
    logic [LVL_W-1:0]     w_quo;
    logic                 w_div_done;

    assign w_now = TIME_BITS'(i_now_ms);
    assign w_e_c = CW'(r_e);
    assign w_ah  = {2'b00, r_first} + {2'b00, r_hold};
    assign w_ahb = w_ah + {2'b00, r_second};
    assign w_e24 = REG_W'(r_e);
    assign w_x24 = REG_W'(w_e_c - CW'(w_ah));
    assign w_fo  = (r_mode == MODE_FADE_OUT);

    // ramp: dividend num * 2^FRACTION_BITS, first bit pre-shifted into the remainder
    assign w_rem = w_div_ctl.blink ? '0 : (w_num >> 1);
    assign w_dvd = w_div_ctl.blink ? DVD_BITS'(r_e)
                                   : {w_num[0], {(DVD_BITS-1){1'b0}}};

    always_comb begin
        n_state     = r_state;
        n_mode      = r_mode;
        n_active    = r_active;
        n_start     = r_start;
        n_e         = r_e;
        n_level     = r_level;
        n_out_valid = r_out_valid;
        n_vis       = r_vis;
        n_run       = r_run;
        w_div_ctl   = '0;
        w_num       = '0;
        w_dsr       = '0;

        if (r_out_valid && i_out_ready) begin
            n_out_valid = 1'b0;
        end

        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    if (i_opcode != OP_TICK) begin
                        n_mode   = i_opcode;
                        n_active = 1'b1;
                        n_start  = w_now;
                        n_level  = ONE;
                        n_state  = S_DONE;
                    end else if (r_active) begin
                        n_e     = w_now - r_start;
                        n_state = S_DECIDE;
                    end else begin
                        n_state = S_DONE;
                    end
                end
            end
            S_DECIDE: begin
                n_state = S_DONE;
                if (r_mode == MODE_BLINK) begin
                    if (w_e_c > CW'(r_total)) begin
                        n_active = 1'b0;
                    end else if (r_period == '0) begin
                        n_level = ONE;
                    end else begin
                        w_div_ctl.start = 1'b1;
                        w_div_ctl.blink = 1'b1;
                        w_dsr           = r_period;
                        n_state         = S_DIV;
                    end
                end else if (r_mode == MODE_FADE_OUT || r_mode == MODE_FADE_IN) begin
                    if (w_e_c > CW'(w_ahb)) begin
                        n_active = 1'b0;
                        n_level  = ONE;
                    end else if (r_first != '0 && w_e_c <= CW'(r_first)) begin
                        w_div_ctl.start = 1'b1;
                        w_num           = w_fo ? (r_first - w_e24) : w_e24;
                        w_dsr           = r_first;
                        n_state         = S_DIV;
                    end else if (r_hold != '0 && w_e_c <= CW'(w_ah)) begin
                        n_level = w_fo ? '0 : ONE;
                    end else if (r_second == '0) begin
                        // empty second ramp lands straight on its end value
                        n_level = w_fo ? ONE : '0;
                    end else begin
                        w_div_ctl.start = 1'b1;
                        w_num           = w_fo ? w_x24 : (r_second - w_x24);
                        w_dsr           = r_second;
                        n_state         = S_DIV;
                    end
                end
            end
            S_DIV: begin
                if (w_div_done) begin
                    if (r_mode == MODE_BLINK) begin
                        n_level = w_quo[0] ? '0 : ONE;
                    end else begin
                        n_level = w_quo;
                    end
                    n_state = S_DONE;
                end
            end
            S_DONE: begin
                if (!r_out_valid || i_out_ready) begin
                    n_vis       = r_level;
                    n_run       = r_active;
                    n_out_valid = 1'b1;
                    n_state     = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_mode      <= MODE_NONE;
            r_active    <= 1'b0;
            r_start     <= '0;
            r_level     <= ONE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_mode      <= n_mode;
            r_active    <= n_active;
            r_start     <= n_start;
            r_level     <= n_level;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_e   <= n_e;
        r_vis <= n_vis;
        r_run <= n_run;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_first  <= '0;
            r_hold   <= '0;
            r_second <= '0;
            r_total  <= '0;
            r_period <= '0;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                CFG_FIRST_RAMP:   r_first  <= i_cfg_data;
                CFG_HOLD:         r_hold   <= i_cfg_data;
                CFG_SECOND_RAMP:  r_second <= i_cfg_data;
                CFG_BLINK_TOTAL:  r_total  <= i_cfg_data;
                CFG_BLINK_PERIOD: r_period <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    fhfbe_div #(
        .DVD_BITS (DVD_BITS),
        .QUO_BITS (LVL_W),
        .CNT_W    (CNT_W)
    ) u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (w_div_ctl),
        .i_dvd   (w_dvd),
        .i_rem   (w_rem),
        .i_dsr   (w_dsr),
        .o_quo   (w_quo),
        .o_done  (w_div_done)
    );

    assign o_in_ready   = (r_state == S_IDLE);
    assign o_out_valid  = r_out_valid;
    assign o_visibility = r_vis;
    assign o_running    = r_run;
    assign o_cfg_ready  = 1'b1;

endmodule

`default_nettype wire

[rtl/core/fhfbe_chk.sv]
// ----------------------------------------------------------------------------
// fhfbe_chk: port-level checks for the envelope generator
// watches the request and result channels of the top level over time
// ----------------------------------------------------------------------------
`default_nettype none

module fhfbe_chk #(
    parameter int FRACTION_BITS = 16
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_in_valid,
    input  logic                    o_in_ready,
    input  logic [1:0]              i_opcode,
    input  logic                    o_out_valid,
    input  logic                    i_out_ready,
    input  logic [FRACTION_BITS:0]  o_visibility,
    input  logic                    o_running
);
    import fhfbe_pkg::*;

    localparam logic [FRACTION_BITS:0] ONE = {1'b1, {FRACTION_BITS{1'b0}}};

    // one request in flight at a time
    a_one_in_flight: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && o_in_ready |=> !o_in_ready)
        else $error("request accepted while a previous one is still in flight");

    a_result_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=>
            o_out_valid && $stable(o_visibility) && $stable(o_running))
        else $error("stalled result changed or dropped");

    a_level_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> o_visibility <= ONE)
        else $error("visibility above full scale");

    // a start request reports full visibility and a running envelope
    a_start_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && o_in_ready && i_opcode != OP_TICK && !o_out_valid |=>
            ##1 (o_out_valid && o_running && o_visibility == ONE))
        else $error("start request did not report a full running envelope");

endmodule

bind fade_hold_fade_blink_envelope fhfbe_chk #(
    .FRACTION_BITS (FRACTION_BITS)
) u_fhfbe_chk (.*);

`default_nettype wire

[test/fade_hold_fade_blink_envelope_chk.sv]
// ----------------------------------------------------------------------------
// fade_hold_fade_blink_envelope_chk: result checker for the envelope block
// Watches the request, result and configuration channels, keeps its own
// copy of the envelope state and registers, predicts the level report of
// every accepted request and compares each accepted result in order.
// ----------------------------------------------------------------------------
module fade_hold_fade_blink_envelope_chk #(
    parameter int TIME_BITS     = 32,
    parameter int FRACTION_BITS = 16
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_req_valid,
    input  logic                              i_req_ready,
    input  logic [1:0]                        i_req_opcode,
    input  logic [fhfbe_pkg::NOW_W-1:0]       i_req_now,
    input  logic                              i_res_valid,
    input  logic                              i_res_ready,
    input  logic [FRACTION_BITS:0]            i_res_visibility,
    input  logic                              i_res_running,
    input  logic                              i_cfg_valid,
    input  logic                              i_cfg_ready,
    input  logic [fhfbe_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  logic [fhfbe_pkg::REG_W-1:0]       i_cfg_data,
    output int                                o_errors,
    output int                                o_waiting,
    output int                                o_results
);
    import fhfbe_pkg::*;

    localparam logic [63:0] FULL_LEVEL = 64'd1 << FRACTION_BITS;
    localparam logic [63:0] TIME_MASK  = (TIME_BITS >= 64) ? '1 : ((64'd1 << TIME_BITS) - 1);

    typedef struct packed {
        logic [FRACTION_BITS:0] visibility;
        logic                   running;
    } t_level_report;

    t_level_report expected_reports[$];

    logic [63:0] ramp1_ms;
    logic [63:0] hold_len_ms;
    logic [63:0] ramp2_ms;
    logic [63:0] blink_total;
    logic [63:0] blink_half;

    logic [1:0]  env_mode;
    logic        env_active;
    logic [63:0] env_stamp;
    logic [63:0] env_level;

    int err_count;
    int result_count;
    int n_waiting;

    assign o_errors  = err_count;
    assign o_waiting = n_waiting;
    assign o_results = result_count;

    function automatic logic [63:0] rise_level(input logic [63:0] x, input logic [63:0] d);
        logic [63:0] xc;
        if (d == 0) return FULL_LEVEL;
        xc = (x > d) ? d : x;
        return (xc * FULL_LEVEL) / d;
    endfunction

    function automatic logic [63:0] fall_level(input logic [63:0] x, input logic [63:0] d);
        logic [63:0] xc;
        if (d == 0) return 64'd0;
        xc = (x > d) ? d : x;
        return ((d - xc) * FULL_LEVEL) / d;
    endfunction

    task automatic combo_update(input logic [63:0] e, input logic fade_out);
        logic [63:0] a;
        logic [63:0] h;
        logic [63:0] b;
        logic [63:0] x;
        a = ramp1_ms;
        h = hold_len_ms;
        b = ramp2_ms;
        if (e > a + h + b) begin
            env_active = 1'b0;
            env_level  = FULL_LEVEL;
        end else if (a != 0 && e <= a) begin
            env_level = fade_out ? fall_level(e, a) : rise_level(e, a);
        end else if (h != 0 && e <= a + h) begin
            env_level = fade_out ? 64'd0 : FULL_LEVEL;
        end else begin
            // zero-length second ramp lands here only at its own end
            x = e - a - h;
            env_level = fade_out ? rise_level(x, b) : fall_level(x, b);
        end
    endtask

    task automatic blink_update(input logic [63:0] e);
        if (e > blink_total) begin
            // expiry keeps whatever level was last shown
            env_active = 1'b0;
        end else if (blink_half == 0) begin
            env_level = FULL_LEVEL;
        end else begin
            env_level = ((e / blink_half) & 64'd1) ? 64'd0 : FULL_LEVEL;
        end
    endtask

    task automatic take_request(input logic [1:0] op, input logic [NOW_W-1:0] now);
        logic [63:0]   t;
        logic [63:0]   e;
        t_level_report rep;
        t = {{(64-NOW_W){1'b0}}, now} & TIME_MASK;
        if (op != OP_TICK) begin
            env_mode   = op;
            env_active = 1'b1;
            env_stamp  = t;
            env_level  = FULL_LEVEL;
        end else if (env_active) begin
            e = (t - env_stamp) & TIME_MASK;
            case (env_mode)
                MODE_FADE_OUT: combo_update(e, 1'b1);
                MODE_FADE_IN:  combo_update(e, 1'b0);
                MODE_BLINK:    blink_update(e);
                default: ;
            endcase
        end
        rep.visibility = env_level[FRACTION_BITS:0];
        rep.running    = env_active;
        expected_reports.push_back(rep);
    endtask

    task automatic check_result();
        t_level_report exp_rep;
        t_level_report got;
        got.visibility = i_res_visibility;
        got.running    = i_res_running;
        if (expected_reports.size() == 0) begin
            if (err_count < 10)
                $display("result with no request waiting: vis=%0d run=%0d",
                         got.visibility, got.running);
            err_count++;
        end else begin
            exp_rep = expected_reports.pop_front();
            if (got.visibility !== exp_rep.visibility || got.running !== exp_rep.running) begin
                if (err_count < 10)
                    $display("mismatch on result %0d: expected vis=%0d run=%0d, got vis=%0d run=%0d",
                             result_count, exp_rep.visibility, exp_rep.running,
                             got.visibility, got.running);
                err_count++;
            end
            result_count++;
        end
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            ramp1_ms     = 0;
            hold_len_ms  = 0;
            ramp2_ms     = 0;
            blink_total  = 0;
            blink_half   = 0;
            env_mode     = MODE_NONE;
            env_active   = 1'b0;
            env_stamp    = 0;
            env_level    = FULL_LEVEL;
            err_count    = 0;
            result_count = 0;
            expected_reports.delete();
        end else begin
            if (i_cfg_valid && i_cfg_ready) begin
                case (i_cfg_index)
                    CFG_FIRST_RAMP:   ramp1_ms    = {40'd0, i_cfg_data};
                    CFG_HOLD:         hold_len_ms = {40'd0, i_cfg_data};
                    CFG_SECOND_RAMP:  ramp2_ms    = {40'd0, i_cfg_data};
                    CFG_BLINK_TOTAL:  blink_total = {40'd0, i_cfg_data};
                    CFG_BLINK_PERIOD: blink_half  = {40'd0, i_cfg_data};
                    default: ;
                endcase
            end
            if (i_req_valid && i_req_ready)
                take_request(i_req_opcode, i_req_now);
            if (i_res_valid && i_res_ready)
                check_result();
        end
        n_waiting = expected_reports.size();
    end

endmodule

[test/fade_hold_fade_blink_envelope_tb.sv]
// ----------------------------------------------------------------------------
// fade_hold_fade_blink_envelope_tb: stimulus and verdict for the envelope
// Directed requests cover every phase, wrap of the time stamp, restarts,
// zero-length phases and full-size registers; random envelope runs follow
// under changing register settings, with random idling on both channels.
// ----------------------------------------------------------------------------
module fade_hold_fade_blink_envelope_tb;
    import fhfbe_pkg::*;

    localparam int TIME_BITS     = 32;
    localparam int FRACTION_BITS = 16;
    localparam int CYCLE_LIMIT   = 600000;
    localparam int RANDOM_ITEMS  = 800;

    logic                   i_clk;
    logic                   i_rst_n;
    logic                   req_valid;
    logic                   req_ready;
    logic [1:0]             req_opcode;
    logic [NOW_W-1:0]       req_now;
    logic                   res_valid;
    logic                   res_ready;
    logic [FRACTION_BITS:0] res_visibility;
    logic                   res_running;
    logic                   cfg_valid;
    logic                   cfg_ready;
    logic [CFG_IDX_W-1:0]   cfg_index;
    logic [REG_W-1:0]       cfg_data;

    int err_total;
    int n_waiting;
    int n_results;

    int  n_requests;
    int  n_writes;
    int  n_settings;
    int  cycle_count = 0;
    bit  steady;

    // shadow of the register values, used to aim ticks at the phases
    logic [31:0] cur_first;
    logic [31:0] cur_hold;
    logic [31:0] cur_second;
    logic [31:0] cur_total;
    logic [31:0] cur_period;

    fade_hold_fade_blink_envelope #(
        .TIME_BITS    (TIME_BITS),
        .FRACTION_BITS(FRACTION_BITS)
    ) u_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (req_valid),
        .o_in_ready  (req_ready),
        .i_opcode    (req_opcode),
        .i_now_ms    (req_now),
        .o_out_valid (res_valid),
        .i_out_ready (res_ready),
        .o_visibility(res_visibility),
        .o_running   (res_running),
        .i_cfg_valid (cfg_valid),
        .o_cfg_ready (cfg_ready),
        .i_cfg_index (cfg_index),
        .i_cfg_data  (cfg_data)
    );

    fade_hold_fade_blink_envelope_chk #(
        .TIME_BITS    (TIME_BITS),
        .FRACTION_BITS(FRACTION_BITS)
    ) u_chk (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_req_valid     (req_valid),
        .i_req_ready     (req_ready),
        .i_req_opcode    (req_opcode),
        .i_req_now       (req_now),
        .i_res_valid     (res_valid),
        .i_res_ready     (res_ready),
        .i_res_visibility(res_visibility),
        .i_res_running   (res_running),
        .i_cfg_valid     (cfg_valid),
        .i_cfg_ready     (cfg_ready),
        .i_cfg_index     (cfg_index),
        .i_cfg_data      (cfg_data),
        .o_errors        (err_total),
        .o_waiting       (n_waiting),
        .o_results       (n_results)
    );

    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    // result side: stalls at random except during the steady stretch
    initial begin
        res_ready = 1'b0;
        forever begin
            @(negedge i_clk);
            res_ready = steady ? 1'b1 : ($urandom_range(99) >= 11);
        end
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("timeout after %0d cycles", cycle_count);
            $display("DONE: errors detected");
            $finish;
        end
    end

    task automatic send_request(input logic [1:0] op, input logic [31:0] now);
        @(negedge i_clk);
        while (!steady && $urandom_range(99) < 11) begin
            req_valid = 1'b0;
            @(negedge i_clk);
        end
        req_valid  = 1'b1;
        req_opcode = op;
        req_now    = now;
        @(posedge i_clk);
        while (!req_ready) @(posedge i_clk);
        n_requests++;
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [REG_W-1:0] data);
        @(negedge i_clk);
        cfg_valid = 1'b1;
        cfg_index = idx;
        cfg_data  = data;
        @(posedge i_clk);
        while (!cfg_ready) @(posedge i_clk);
        @(negedge i_clk);
        cfg_valid = 1'b0;
        n_writes++;
        case (idx)
            CFG_FIRST_RAMP:   cur_first  = {8'd0, data};
            CFG_HOLD:         cur_hold   = {8'd0, data};
            CFG_SECOND_RAMP:  cur_second = {8'd0, data};
            CFG_BLINK_TOTAL:  cur_total  = {8'd0, data};
            CFG_BLINK_PERIOD: cur_period = {8'd0, data};
            default: ;
        endcase
    endtask

    // hold off requests until every result is back
    task automatic drain_results();
        @(negedge i_clk);
        req_valid = 1'b0;
        while (n_waiting != 0) @(negedge i_clk);
        repeat (4) @(negedge i_clk);
    endtask

    task automatic load_setting(input logic [REG_W-1:0] a, input logic [REG_W-1:0] h,
                                input logic [REG_W-1:0] b, input logic [REG_W-1:0] total,
                                input logic [REG_W-1:0] period);
        drain_results();
        write_reg(CFG_FIRST_RAMP, a);
        write_reg(CFG_HOLD, h);
        write_reg(CFG_SECOND_RAMP, b);
        write_reg(CFG_BLINK_TOTAL, total);
        write_reg(CFG_BLINK_PERIOD, period);
        n_settings++;
    endtask

    function automatic logic [REG_W-1:0] draw_duration(input int kind);
        case (kind)
            0: return ($urandom_range(4) == 0) ? '0 : REG_W'($urandom_range(1, 40));
            1: return REG_W'($urandom_range(0, 3000));
            2: begin
                case ($urandom_range(2))
                    0: return '0;
                    1: return '1;
                    default: return REG_W'($urandom);
                endcase
            end
            default: return REG_W'($urandom);
        endcase
    endfunction

    task automatic random_setting(input int kind);
        load_setting(draw_duration(kind), draw_duration(kind), draw_duration(kind),
                     draw_duration(kind), draw_duration(kind));
        // indexes above the register map are ignored by the block
        if ($urandom_range(3) == 0)
            write_reg(CFG_BLINK_PERIOD + CFG_IDX_W'($urandom_range(1, 3)), REG_W'($urandom));
    endtask

    function automatic logic [31:0] envelope_span(input logic [1:0] op);
        return (op == OP_BLINK) ? cur_total : cur_first + cur_hold + cur_second;
    endfunction

    // one start request followed by ticks aimed at its phases, with restarts at random
    task automatic run_envelope();
        logic [1:0]  op;
        logic [31:0] base;
        logic [31:0] span;
        logic [31:0] e;
        int          n_ticks;
        op      = 2'($urandom_range(1, 3));
        base    = $urandom;
        span    = envelope_span(op);
        n_ticks = $urandom_range(2, 8);
        send_request(op, base);
        for (int k = 0; k < n_ticks; k++) begin
            case ($urandom_range(9))
                0, 1, 2, 3, 4, 5: e = $urandom_range(0, span + span / 4 + 2);
                6: begin
                    case ($urandom_range(4))
                        0: e = 0;
                        1: e = (op == OP_BLINK) ? cur_period : cur_first;
                        2: e = (op == OP_BLINK) ? cur_period * 2 : cur_first + cur_hold;
                        3: e = span;
                        default: e = span + 1;
                    endcase
                end
                7: e = $urandom;
                8: begin
                    // restart while running
                    op   = 2'($urandom_range(1, 3));
                    base = base + $urandom_range(0, span);
                    span = envelope_span(op);
                    send_request(op, base);
                    e = $urandom_range(0, span);
                end
                default: e = span + 1 + $urandom_range(0, 5);
            endcase
            send_request(OP_TICK, base + e);
        end
    endtask

    initial begin
        int random_base;
        int phase_base;
        i_rst_n     = 1'b0;
        req_valid   = 1'b0;
        req_opcode  = OP_TICK;
        req_now     = '0;
        cfg_valid   = 1'b0;
        cfg_index   = CFG_FIRST_RAMP;
        cfg_data    = '0;
        n_requests  = 0;
        n_writes    = 0;
        n_settings  = 0;
        steady      = 1'b0;
        cur_first   = 0;
        cur_hold    = 0;
        cur_second  = 0;
        cur_total   = 0;
        cur_period  = 0;
        repeat (6) @(negedge i_clk);
        i_rst_n = 1'b1;

        // tick straight after reset: nothing running
        send_request(OP_TICK, 32'd123);

        load_setting(24'd10, 24'd5, 24'd8, 24'd20, 24'd4);
        send_request(OP_FADE_OUT, 32'hFFFF_FFFC);
        send_request(OP_TICK, 32'hFFFF_FFFC + 32'd5);
        send_request(OP_TICK, 32'hFFFF_FFFC + 32'd12);
        send_request(OP_TICK, 32'hFFFF_FFFC + 32'd19);
        send_request(OP_TICK, 32'hFFFF_FFFC + 32'd24);
        send_request(OP_FADE_IN, 32'd100);
        send_request(OP_TICK, 32'd103);
        send_request(OP_FADE_OUT, 32'd200);
        send_request(OP_BLINK, 32'd0);
        send_request(OP_TICK, 32'd5);
        send_request(OP_TICK, 32'd21);
        send_request(OP_TICK, 32'd500);

        // zero-length phases, blink with no toggling
        load_setting(24'd0, 24'd0, 24'd0, 24'hFF_FFFF, 24'd0);
        send_request(OP_FADE_IN, 32'd50);
        send_request(OP_TICK, 32'd50);
        send_request(OP_TICK, 32'd51);
        send_request(OP_FADE_OUT, 32'd7);
        send_request(OP_TICK, 32'd7);
        send_request(OP_BLINK, 32'hFFFF_0000);
        send_request(OP_TICK, 32'hFFFF_FFFF);

        load_setting('1, '1, '1, '1, '1);
        send_request(OP_FADE_OUT, 32'd0);
        send_request(OP_TICK, 32'h00FF_FFFF);
        send_request(OP_TICK, 32'h02FF_FFFD);
        send_request(OP_BLINK, 32'd0);
        send_request(OP_TICK, 32'h00FF_FFFF);

        random_base = n_requests;
        while (n_requests - random_base < RANDOM_ITEMS) begin
            random_setting($urandom_range(0, 3));
            phase_base = n_requests;
            while (n_requests - phase_base < 50 && n_requests - random_base < RANDOM_ITEMS) begin
                steady = (n_requests - random_base >= 300) && (n_requests - random_base < 420);
                if ($urandom_range(99) < 15)
                    send_request(2'($urandom_range(0, 3)), $urandom);
                else
                    run_envelope();
            end
        end
        steady = 1'b0;

        drain_results();
        repeat (50) @(negedge i_clk);
        $display("covered %0d requests and %0d results under %0d register settings",
                 n_requests, n_results, n_settings);
        $display("%0d register writes, %0d cycles", n_writes, cycle_count);
        if (err_total == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule

[files.f]
rtl/core/fhfbe_pkg.sv
rtl/core/fhfbe_div.sv
rtl/core/fade_hold_fade_blink_envelope.sv
rtl/core/fhfbe_chk.sv
test/fade_hold_fade_blink_envelope_chk.sv
test/fade_hold_fade_blink_envelope_tb.sv
